/* src/bdiou_pkg.sv */
// package: widths and types for the distance-iou scorer
`default_nettype none
package bdiou_pkg;
   localparam int CoordBits = 12;
   localparam int FracBits = 14;
   localparam int ScoreBits = 16;
   localparam int EdgeBits = CoordBits + 1;
   localparam int AreaBits = 2 * EdgeBits;
   localparam int CtrBits = CoordBits + 3;
   localparam int DistBits = 2 * CtrBits + 1;
   localparam int QBits = FracBits + 1;
   localparam int NumBits = AreaBits + FracBits;
   localparam int DNumBits = DistBits + FracBits;
   localparam int DivSteps = QBits;
   localparam int StepsPerStage = 3;
   localparam int DivStages = (DivSteps + StepsPerStage - 1) / StepsPerStage;
   localparam int DRemBits = DistBits + 3;

   typedef logic [QBits-1:0] q_type;
endpackage
`default_nettype wire

/* src/bdiou_div.sv */
// pipelined restoring divider, a few quotient bits per stage, stallable
`default_nettype none
module bdiou_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic advance,
   input  wire logic [bdiou_pkg::DRemBits-1:0] num,
   input  wire logic [bdiou_pkg::DRemBits-1:0] den,
   output bdiou_pkg::q_type quot
);
   import bdiou_pkg::*;

   logic [DRemBits-1:0] rem_ff [DivStages+1];
   logic [DRemBits-1:0] den_ff [DivStages+1];
   q_type q_ff [DivStages+1];
   logic [DRemBits-1:0] rem_in [DivStages];
   q_type q_in [DivStages];

   // quotient bits produced msb first; num <= den, remainder doubled after the integer bit
   always_comb begin
      for (int s = 0; s < DivStages; s++) begin
         logic [DRemBits:0] r;
         logic [DRemBits:0] t;
         r = {1'b0, rem_ff[s]};
         t = '0;
         q_in[s] = q_ff[s];
         for (int k = 0; k < StepsPerStage; k++) begin
            if (s * StepsPerStage + k < DivSteps) begin
               if (s * StepsPerStage + k != 0) r = r << 1;
               t = r - {1'b0, den_ff[s]};
               if (!t[DRemBits]) begin
                  r = t;
                  q_in[s][DivSteps - 1 - (s * StepsPerStage + k)] = 1'b1;
               end
            end
         end
         rem_in[s] = r[DRemBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         q_ff[0] <= '0;
         for (int s = 0; s < DivStages; s++) begin
            rem_ff[s+1] <= rem_in[s];
            den_ff[s+1] <= den_ff[s];
            q_ff[s+1] <= q_in[s];
         end
      end
   end

   assign quot = q_ff[DivStages];

   logic unused;
   assign unused = reset ^ (|rem_ff[DivStages]) ^ (|den_ff[DivStages]);
endmodule
`default_nettype wire

/* src/box_distance_iou_score_top.sv */
// top level: distance-iou score of two boxes, fully pipelined
`default_nettype none
// Accepts one box pair per cycle while the pipeline advances and returns one
// word per pair through extents, products, sums, then two parallel pipelined
// dividers of three quotient bits per stage. The whole pipeline advances
// whenever the output register is empty or taken, so throughput is one pair
// per cycle while results are taken; a stall freezes every stage, bubbles
// included.
module box_distance_iou_score_top (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [11:0] req_a_left,
   input  wire logic [11:0] req_a_top,
   input  wire logic [11:0] req_a_width,
   input  wire logic [11:0] req_a_height,
   input  wire logic [11:0] req_b_left,
   input  wire logic [11:0] req_b_top,
   input  wire logic [11:0] req_b_width,
   input  wire logic [11:0] req_b_height,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic signed [15:0] rsp_score,
   output logic rsp_no_overlap
);
   import bdiou_pkg::*;

   localparam int Lat = 3 + DivStages;
   logic advance;
   logic [Lat:0] vld_ff;
   logic [Lat:0] nov_ff;

   assign advance = !vld_ff[Lat] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[Lat];

   // stage 1: extents
   logic signed [EdgeBits:0] iw_in, ih_in;
   logic [EdgeBits-1:0] ar, ab, br, bb;
   logic [EdgeBits-1:0] ex_ff, ey_ff, aw_ff, ah_ff, bw_ff, bh_ff, iw_ff, ih_ff;
   logic signed [CtrBits-1:0] dx_ff, dy_ff;
   always_comb begin
      ar = EdgeBits'(req_a_left) + EdgeBits'(req_a_width);
      ab = EdgeBits'(req_a_top) + EdgeBits'(req_a_height);
      br = EdgeBits'(req_b_left) + EdgeBits'(req_b_width);
      bb = EdgeBits'(req_b_top) + EdgeBits'(req_b_height);
      iw_in = $signed({1'b0, (ar < br ? ar : br)})
            - $signed({2'b0, (req_a_left > req_b_left ? req_a_left : req_b_left)});
      ih_in = $signed({1'b0, (ab < bb ? ab : bb)})
            - $signed({2'b0, (req_a_top > req_b_top ? req_a_top : req_b_top)});
   end

   // stage 2: products
   logic [AreaBits-1:0] inter_ff, aa_ff, ba_ff;
   logic [DistBits-2:0] dxx_ff, dyy_ff;
   logic [AreaBits+1:0] exx_ff;
   // stage 3: sums
   logic [DRemBits-1:0] inum_ff, iden_ff, dnum_ff, dden_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         iw_ff <= iw_in[EdgeBits-1:0];
         ih_ff <= ih_in[EdgeBits-1:0];
         nov_ff[0] <= iw_in <= 0 || ih_in <= 0;
         ex_ff <= (ar > br ? ar : br)
                - EdgeBits'(req_a_left < req_b_left ? req_a_left : req_b_left);
         ey_ff <= (ab > bb ? ab : bb)
                - EdgeBits'(req_a_top < req_b_top ? req_a_top : req_b_top);
         aw_ff <= EdgeBits'(req_a_width);
         ah_ff <= EdgeBits'(req_a_height);
         bw_ff <= EdgeBits'(req_b_width);
         bh_ff <= EdgeBits'(req_b_height);
         dx_ff <= $signed(CtrBits'(ar) + CtrBits'(req_a_left))
                - $signed(CtrBits'(br) + CtrBits'(req_b_left));
         dy_ff <= $signed(CtrBits'(ab) + CtrBits'(req_a_top))
                - $signed(CtrBits'(bb) + CtrBits'(req_b_top));

         inter_ff <= iw_ff * ih_ff;
         aa_ff <= aw_ff * ah_ff;
         ba_ff <= bw_ff * bh_ff;
         dxx_ff <= (DistBits-1)'(dx_ff * dx_ff);
         dyy_ff <= (DistBits-1)'(dy_ff * dy_ff);
         exx_ff <= (AreaBits+2)'(ex_ff * ex_ff) + (AreaBits+2)'(ey_ff * ey_ff);

         inum_ff <= DRemBits'(inter_ff);
         iden_ff <= DRemBits'(aa_ff) + DRemBits'(ba_ff) - DRemBits'(inter_ff);
         dnum_ff <= DRemBits'(dxx_ff) + DRemBits'(dyy_ff);
         dden_ff <= DRemBits'(exx_ff) << 2;
         for (int s = 1; s <= Lat; s++) nov_ff[s] <= nov_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Lat-1:0], req_valid};
      end
   end

   q_type iou_q, dst_q;
   logic [DRemBits-1:0] inum_g, iden_g, dnum_g, dden_g;
   // overlap-free items get den of 1 so the divider stays defined
   assign inum_g = nov_ff[2] ? '0 : inum_ff;
   assign iden_g = nov_ff[2] ? DRemBits'(1) : iden_ff;
   assign dnum_g = nov_ff[2] ? '0 : dnum_ff;
   assign dden_g = nov_ff[2] ? DRemBits'(1) : dden_ff;

   bdiou_div u_iou (.clock, .reset, .advance, .num(inum_g), .den(iden_g), .quot(iou_q));
   bdiou_div u_dst (.clock, .reset, .advance, .num(dnum_g), .den(dden_g), .quot(dst_q));

   logic signed [QBits:0] diff;
   assign diff = $signed({1'b0, iou_q}) - $signed({1'b0, dst_q});
   assign rsp_score = nov_ff[Lat] ? -16'sd16384 : ScoreBits'(diff);
   assign rsp_no_overlap = nov_ff[Lat];

`ifndef SYNTH
   a_nov_score: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_overlap |-> rsp_score == -16'sd16384) else $error("nov score");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_score)) else $error("hold");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_score <= 16'sd16384 && rsp_score >= -16'sd16384) else $error("range");
`endif
endmodule
`default_nettype wire
